// File: src/bph_pkg.sv
package bph_pkg;

  localparam int unsigned CNT_W    = 16;
  localparam int unsigned PARAM_W  = 32;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned SCALE_W  = 3;
  localparam int unsigned MAX_CHAN = 32;

  // Scale that selects the full bank of counters.
  localparam logic [SCALE_W-1:0] SCALE_FULL  = 3'd5;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 3'd5;

  // Register index of scale_log2 (byte address 4 * index).
  localparam logic REG_SCALE = 1'b0;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    REQ_EVENT = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               value_valid;
    logic [PARAM_W-1:0] param_value;
    logic [CHAN_W-1:0]  channel;
    logic [CNT_W-1:0]   write_value;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] read_data;
    logic             status;
  } result_t;

  // Hand-off from the input register to the counter bank.
  typedef struct packed {
    logic  fire;
    item_t item;
  } stage_t;

endpackage

// File: src/bit_pattern_histogram_unit.sv
// Channel  | Direction | Contents
// ---------+-----------+-----------------------------------------------------
// in_      | slave     | one request: event, channel read or channel write
// out_     | master    | one result per request: read data and status
// cfg_     | APB write | scale_log2 at byte address 0
//
// A request is held in an input register. When the result register is free, the bank
// applies it and the result register loads, raising out_tvalid. One transaction a
// cycle is taken while out_ is not stalled, set by the single pass through the bank.
// Reset is synchronous, clears every counter at once and returns scale_log2 to five.
// A stalled result register holds the input register, and in_tready falls only while
// both registers are full and out_tready is low.
module bit_pattern_histogram_unit
  import bph_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // param_value, channel, write_value, zero fill
  input  logic [2:0]  in_tuser,   // req_type, value_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_data
  output logic [0:0]  out_tuser,  // status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [SCALE_W-1:0] scale_r;
  logic [SCALE_W-1:0] scale_nxt;
  logic               cfg_wr;
  item_t              in_item;
  stage_t             stage;
  result_t            bank_res;
  result_t            out_res;
  logic               out_free;

  // The register index is the word address; the byte offset bits are unused.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    scale_nxt = scale_r;
    if (cfg_wr && (cfg_paddr[2] == REG_SCALE)) begin
      scale_nxt = cfg_pwdata[SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SCALE) ? {29'd0, scale_r} : 32'd0;

  // Unpack the request: tuser carries the kind, tdata the payload.
  assign in_item.req_type    = in_tuser[1:0];
  assign in_item.value_valid = in_tuser[2];
  assign in_item.param_value = in_tdata[31:0];
  assign in_item.channel     = in_tdata[36:32];
  assign in_item.write_value = in_tdata[52:37];

  bph_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_free (out_free),
    .stage    (stage)
  );

  bph_counter_bank #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .scale  (scale_r),
    .stage  (stage),
    .result (bank_res)
  );

  // The result register loads at the edge the counters take the update.
  bph_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (stage.fire),
    .result     (bank_res),
    .out_free   (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_res)
  );

  assign out_tdata    = out_res.read_data;
  assign out_tuser[0] = out_res.status;

endmodule

// File: src/bph_in_stage.sv
module bph_in_stage
  import bph_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  item_t  in_item,
  input  logic   out_free,
  output stage_t stage
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  fire;

  // The held item moves on whenever the result register can take it.
  assign fire     = valid_r && out_free;
  assign in_ready = !valid_r || out_free;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage.fire = fire;
  assign stage.item = item_r;

endmodule

// File: src/bph_counter_bank.sv
module bph_counter_bank
  import bph_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SCALE_W-1:0] scale,
  input  stage_t             stage,
  output result_t            result
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [CNT_W-1:0]        cnt_r   [NUM_CHANNELS];
  logic [CNT_W-1:0]        cnt_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] active;
  logic                    full_scale;
  logic                    chan_ok;
  logic [IDX_W-1:0]        rd_idx;
  item_t                   it;

  assign it         = stage.item;
  assign full_scale = (scale >= SCALE_FULL);

  // Channel i is live when it lies below two to the power of the scale.
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      active[i] = full_scale || ((CHAN_W'(i) >> scale) == '0);
    end
  end

  assign chan_ok = ({1'b0, it.channel} < (CHAN_W + 1)'(NUM_CHANNELS))
                   && (full_scale || ((it.channel >> scale) == '0));
  assign rd_idx  = it.channel[IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (stage.fire) begin
        case (it.req_type)
          REQ_EVENT: begin
            if (it.value_valid && it.param_value[i] && active[i]) begin
              cnt_nxt[i] = cnt_r[i] + 1'b1;
            end
          end
          REQ_WRITE: begin
            if (chan_ok && (it.channel == CHAN_W'(i))) begin
              cnt_nxt[i] = it.write_value;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!rst_n) begin
        cnt_r[i] <= '0;
      end else begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_comb begin
    result.read_data = '0;
    result.status    = STATUS_OK;
    case (it.req_type)
      REQ_READ: begin
        if (chan_ok) begin
          result.read_data = cnt_r[rd_idx];
        end else begin
          result.status = STATUS_RANGE;
        end
      end
      REQ_WRITE: begin
        if (!chan_ok) begin
          result.status = STATUS_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/bph_out_stage.sv
module bph_out_stage
  import bph_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule

// File: src/bph_checker.sv
module bph_checker
  import bph_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        cfg_pready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  a_range_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] == STATUS_RANGE)) |-> (out_tdata == '0))
    else $error("refused request returned data");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port inserted a wait state");

endmodule

bind bit_pattern_histogram_unit bph_checker u_bph_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

// File: dv/tb_bit_pattern_histogram_unit.sv
// Testbench for the bit-pattern histogram unit.
//
// Requests go in on the in_ stream, and one result per request comes back
// on the out_ stream. A predictor in this file keeps its own copy of the
// channel counters and of scale_log2. It works out the result of every
// input transaction at the moment it is accepted and queues it. A monitor
// compares each output transaction, field by field, with the oldest
// queued result.
module tb_bit_pattern_histogram_unit;
  import bph_pkg::*;

  localparam int unsigned NCHAN = 32;

  // Request code that the block has no use for; it must change nothing.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // Register addresses. Index 1 lies past the end of the register list.
  localparam logic [2:0] CFG_ADDR_SCALE = {REG_SCALE, 2'b00};
  localparam logic [2:0] CFG_ADDR_SPARE = 3'd4;

  // Length of the long receiver hold-off, in clock cycles.
  localparam int unsigned LONG_HOLD = 300;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata    = '0;  // param_value, channel, write_value, zero fill
  logic [2:0]  in_tuser    = '0;  // req_type, value_valid
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;         // read_data
  logic [0:0]  out_tuser;         // status
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit_pattern_histogram_unit #(
    .NUM_CHANNELS(NCHAN)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Predicted state of the block: the counter bank and the scale register.
  logic [CNT_W-1:0]   bank_model [NCHAN];
  logic [SCALE_W-1:0] scale_model;

  // Results still owed by the block, oldest first.
  result_t expected_results[$];

  int mismatches = 0;

  // Idling controls. The sender and the receiver each idle in random
  // bursts while their flag is set; long_hold_req asks the receiver for
  // one long hold-off, which the receiver process counts out itself.
  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;
  bit long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the length of the run, far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Number of active channels for a given scale. Scales of 6 and 7, or any
  // scale whose power of two exceeds the bank, select the whole bank.
  function automatic int unsigned active_channels(logic [SCALE_W-1:0] scale);
    int unsigned n;
    if (scale > SCALE_FULL) begin
      n = MAX_CHAN;
    end else begin
      n = 1 << scale;
    end
    if (n > NCHAN) begin
      n = NCHAN;
    end
    return n;
  endfunction

  // Applies one request to the predicted counter bank and returns the
  // result that the block should give for it.
  function automatic result_t histogram_step(item_t it);
    result_t     res;
    int unsigned n;
    n = active_channels(scale_model);
    res.read_data = '0;
    res.status    = STATUS_OK;
    case (it.req_type)
      REQ_EVENT: begin
        // An event without a valid parameter leaves every counter alone.
        // Parameter bits above the active range are ignored.
        if (it.value_valid) begin
          for (int i = 0; i < n; i++) begin
            if (it.param_value[i]) begin
              bank_model[i] = bank_model[i] + 1'b1;  // wraps from 65535 to 0
            end
          end
        end
      end
      REQ_READ: begin
        if (it.channel < n) begin
          res.read_data = bank_model[it.channel];
        end else begin
          res.status = STATUS_RANGE;
        end
      end
      REQ_WRITE: begin
        if (it.channel < n) begin
          bank_model[it.channel] = it.write_value;
        end else begin
          res.status = STATUS_RANGE;
        end
      end
      default: begin
        // The spare request code is answered with a plain OK.
      end
    endcase
    return res;
  endfunction

  // Sends one request. It is called at a falling edge and returns at the
  // falling edge after the transaction, with tvalid still high, so that
  // back-to-back requests keep tvalid up without a glitch.
  task automatic send_request(logic [1:0] req, logic valid, logic [PARAM_W-1:0] param,
                              logic [CHAN_W-1:0] chan, logic [CNT_W-1:0] wval);
    item_t it;
    it.req_type    = req;
    it.value_valid = valid;
    it.param_value = param;
    it.channel     = chan;
    it.write_value = wval;
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, it.write_value, it.channel, it.param_value};
    in_tuser  <= {it.value_valid, it.req_type};
    do begin
      @(posedge clk);
    end while (!in_tready);
    expected_results.insert(expected_results.size(), histogram_step(it));
    @(negedge clk);
  endtask

  // Stops sending and waits until the block has delivered every result.
  // Since every request gives a result, the block is idle afterwards.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    if (addr == CFG_ADDR_SCALE) begin
      scale_model = data[SCALE_W-1:0];
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // One random request. Most requests are events, reads and writes that
  // name an active channel; the rest reach out of range or use the spare
  // code. Writes often load values close to 65535 so that later events
  // wrap the counters.
  task automatic send_random_request;
    logic [1:0]         req;
    logic               valid;
    logic [PARAM_W-1:0] param;
    logic [CHAN_W-1:0]  chan;
    logic [CNT_W-1:0]   wval;
    int unsigned        pick;
    int unsigned        n;
    n    = active_channels(scale_model);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      req = REQ_EVENT;
    end else if (pick < 72) begin
      req = REQ_READ;
    end else if (pick < 95) begin
      req = REQ_WRITE;
    end else begin
      req = REQ_SPARE;
    end
    valid = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0: param = '1;
      1: param = '0;
      2: param = 32'd1 << $urandom_range(0, 31);
      default: param = $urandom;
    endcase
    if ($urandom_range(0, 4) != 0) begin
      chan = CHAN_W'($urandom_range(0, n - 1));
    end else begin
      chan = CHAN_W'($urandom);
    end
    if ($urandom_range(0, 9) < 3) begin
      wval = CNT_W'(16'hFFFF - $urandom_range(0, 3));
    end else begin
      wval = CNT_W'($urandom);
    end
    send_request(req, valid, param, chan, wval);
  endtask

  // Receiver: drives out_tready at each falling edge. It idles in random
  // bursts and, when asked, holds off for one long stretch.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        hold_left  = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: each output transaction against the oldest queued result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin : check_result
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: read_data %0h status %0h",
               out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.read_data) begin
          $error("read_data: expected %0h, actual %0h", want.read_data, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== want.status) begin
          $error("status: expected %0h, actual %0h", want.status, out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Directed requests: the counters start at zero, events with every bit
  // set, an invalid event, the spare code, counter wrap, reads and writes
  // on either side of the active range at the smallest and a middle
  // scale, a read at an over-range scale, a write past the register list.
  task automatic test_directed;
    send_request(REQ_READ, 1'b0, '0, 5'd0, '0);
    send_request(REQ_READ, 1'b0, '0, 5'd31, '0);
    send_request(REQ_EVENT, 1'b1, '1, 5'd0, '0);
    send_request(REQ_EVENT, 1'b0, '1, 5'd31, '1);
    send_request(REQ_SPARE, 1'b1, '1, 5'd31, '1);
    send_request(REQ_READ, 1'b1, '1, 5'd31, '1);
    send_request(REQ_WRITE, 1'b0, '0, 5'd31, 16'hFFFF);
    send_request(REQ_WRITE, 1'b0, '0, 5'd0, 16'hFFFF);
    send_request(REQ_EVENT, 1'b1, '1, 5'd0, '0);
    send_request(REQ_READ, 1'b0, '0, 5'd0, '0);
    send_request(REQ_READ, 1'b0, '0, 5'd31, '0);
    drain();
    // Smallest scale: only channel 0 is active.
    cfg_write(CFG_ADDR_SCALE, 32'd0);
    send_request(REQ_READ, 1'b0, '0, 5'd1, '0);
    send_request(REQ_WRITE, 1'b0, '0, 5'd1, 16'h5555);
    send_request(REQ_EVENT, 1'b1, '1, 5'd0, '0);
    send_request(REQ_READ, 1'b0, '0, 5'd0, '0);
    drain();
    // Scale above range selects the whole bank.
    cfg_write(CFG_ADDR_SCALE, 32'd7);
    send_request(REQ_READ, 1'b0, '0, 5'd31, '0);
    drain();
    // A write past the register list must leave the scale alone.
    cfg_write(CFG_ADDR_SPARE, 32'd0);
    send_request(REQ_READ, 1'b0, '0, 5'd31, '0);
    drain();
    cfg_write(CFG_ADDR_SCALE, 32'd3);
    send_request(REQ_WRITE, 1'b0, '0, 5'd8, 16'h1234);
    send_request(REQ_WRITE, 1'b0, '0, 5'd7, 16'h1234);
    send_request(REQ_EVENT, 1'b1, 32'hFFFF_FF80, 5'd0, '0);
    send_request(REQ_READ, 1'b0, '0, 5'd7, '0);
    drain();
  endtask

  // Random requests over a sequence of scales, the extremes among them,
  // with the upper bits of the scale register written as noise.
  task automatic test_random_scales;
    logic [SCALE_W-1:0] scales [9] = '{3'd5, 3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd6, 3'd5};
    for (int p = 0; p < 9; p++) begin
      cfg_write(CFG_ADDR_SCALE, {$urandom_range(0, 1) ? $urandom : 32'd0} & ~32'h7
                                | 32'(scales[p]));
      repeat (170) send_random_request();
      drain();
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the block fills up and stalls its input; then the sender waits for
  // every result.
  task automatic test_backpressure;
    long_hold_req = 1'b1;
    repeat (60) send_random_request();
    drain();
  endtask

  // Last part of the run: full rate on both sides.
  task automatic test_full_rate;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (100) send_random_request();
    drain();
  endtask

  initial begin
    for (int i = 0; i < NCHAN; i++) begin
      bank_model[i] = '0;
    end
    scale_model = SCALE_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random_scales();
    test_full_rate();

    // Let the pipeline settle before the verdict.
    repeat (6) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bph_pkg.sv
src/bph_in_stage.sv
src/bph_counter_bank.sv
src/bph_out_stage.sv
src/bit_pattern_histogram_unit.sv
src/bph_checker.sv
dv/tb_bit_pattern_histogram_unit.sv
